// ===== rtl/dqpi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dqpi_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int NAME_BYTES_DEF  = 8;

   localparam logic [3:0] POS_APPEND = 4'd6;
   localparam logic [3:0] POS_HEAD   = 4'd1;

   typedef enum logic [1:0] {
      KIND_APPEND = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_MOVE   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SEL_HOLD,
      SEL_LOAD,
      SEL_LEFT,
      SEL_RIGHT
   } cell_sel_type;

   typedef struct packed {
      logic ins;
      logic pop;
   } row_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/dqpi_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dqpi_cell #(
   parameter int NW = 64
) (
   input  wire                        clock,
   input  dqpi_pkg::cell_sel_type     sel,
   input  wire  [NW-1:0]              new_name,
   input  wire  [31:0]                new_value,
   input  wire  [NW-1:0]              left_name,
   input  wire  [31:0]                left_value,
   input  wire  [NW-1:0]              right_name,
   input  wire  [31:0]                right_value,
   output logic [NW-1:0]              name,
   output logic [31:0]                value
);
   import dqpi_pkg::*;

   logic [NW-1:0] name_ff;
   logic [31:0]   value_ff;

   always_ff @(posedge clock) begin
      unique case (sel)
         SEL_LOAD: begin
            name_ff  <= new_name;
            value_ff <= new_value;
         end
         SEL_LEFT: begin
            name_ff  <= left_name;
            value_ff <= left_value;
         end
         SEL_RIGHT: begin
            name_ff  <= right_name;
            value_ff <= right_value;
         end
         default: begin
            name_ff  <= name_ff;
            value_ff <= value_ff;
         end
      endcase
   end

   assign name  = name_ff;
   assign value = value_ff;

endmodule

`default_nettype wire

// ===== rtl/dqpi_row.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dqpi_row #(
   parameter int DEPTH = 16,
   parameter int CW    = 5,
   parameter int IW    = 4,
   parameter int NW    = 64
) (
   input  wire                     clock,
   input  wire                     reset,
   input  dqpi_pkg::row_ctrl_type  ctrl,
   input  wire  [IW-1:0]           ins_idx,
   input  wire  [NW-1:0]           new_name,
   input  wire  [31:0]             new_value,
   output logic [NW-1:0]           head_name,
   output logic [31:0]             head_value,
   output logic [CW-1:0]           count
);
   import dqpi_pkg::*;

   logic [NW-1:0] cell_name  [DEPTH];
   logic [31:0]   cell_value [DEPTH];
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   always_comb begin
      priority if (ctrl.ins) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      cell_sel_type  sel;
      logic [NW-1:0] l_name;
      logic [31:0]   l_value;
      logic [NW-1:0] r_name;
      logic [31:0]   r_value;

      if (k == 0) begin : g_first
         assign l_name  = new_name;
         assign l_value = new_value;
      end else begin : g_mid
         assign l_name  = cell_name[k-1];
         assign l_value = cell_value[k-1];
      end

      if (k == DEPTH - 1) begin : g_last
         assign r_name  = cell_name[k];
         assign r_value = cell_value[k];
      end else begin : g_inner
         assign r_name  = cell_name[k+1];
         assign r_value = cell_value[k+1];
      end

      always_comb begin
         priority if (ctrl.ins && ins_idx == IW'(k)) begin
            sel = SEL_LOAD;
         end else if (ctrl.ins && ins_idx < IW'(k)) begin
            sel = SEL_LEFT;
         end else if (ctrl.pop) begin
            sel = SEL_RIGHT;
         end else begin
            sel = SEL_HOLD;
         end
      end

      dqpi_cell #(
         .NW(NW)
      ) u_cell (
         .clock       (clock),
         .sel         (sel),
         .new_name    (new_name),
         .new_value   (new_value),
         .left_name   (l_name),
         .left_value  (l_value),
         .right_name  (r_name),
         .right_value (r_value),
         .name        (cell_name[k]),
         .value       (cell_value[k])
      );
   end

   assign head_name  = cell_name[0];
   assign head_value = cell_value[0];
   assign count      = count_ff;

endmodule

`default_nettype wire

// ===== rtl/dual_queue_positional_insert.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two bounded queues of name/value entries with append, positional insert
// and move-head-to-other-queue requests.
// Channels: req_* carries one request item, rsp_* one result item per
// request; both use valid/stall, an item moves when valid is high and
// stall is low.
// The result is registered and presented in the cycle after the request
// is taken. Throughput: one item per cycle while req_stall is low; each
// queue is a row of registered cells that shift, load or hold, and the
// fill counters update in the same cycle as the cells.
// The count outputs always show the current fill counts.
// Reset: both queues become empty, no result is pending. Entry storage
// is not cleared.
// Stall: while a result waits under rsp_stall, req_stall is raised and
// the result stays unchanged; a new request is taken in the same cycle
// the waiting result leaves.

module dual_queue_positional_insert #(
   parameter int QUEUE_DEPTH = dqpi_pkg::QUEUE_DEPTH_DEF,
   parameter int NAME_BYTES  = dqpi_pkg::NAME_BYTES_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire  [1:0]         req_kind,
   input  wire                req_queue_select,
   input  wire  [63:0]        req_entry_name,
   input  wire  signed [31:0] req_entry_value,
   input  wire  [3:0]         req_position,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_count_first,
   output logic [4:0]         rsp_count_second,
   output logic [63:0]        rsp_moved_name,
   output logic signed [31:0] rsp_moved_value
);
   import dqpi_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int NW = 8 * NAME_BYTES;
   localparam int PW = (CW > 4) ? CW : 4;
   localparam int XW = (CW > 5) ? CW : 5;

   logic          acc;
   logic          sel;
   logic          oth;

   logic [CW-1:0] cnt        [2];
   logic [NW-1:0] head_name  [2];
   logic [31:0]   head_value [2];
   row_ctrl_type  ctrl       [2];
   logic [IW-1:0] idx        [2];
   logic [NW-1:0] new_name   [2];
   logic [31:0]   new_value  [2];

   logic [PW-1:0] pos_ext;
   logic [PW-1:0] cnt_ext;
   logic [PW-1:0] ins_idx;

   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   status_type    status_ff;
   status_type    status_in;
   logic [NW-1:0] mv_name_ff;
   logic [NW-1:0] mv_name_in;
   logic [31:0]   mv_value_ff;
   logic [31:0]   mv_value_in;
   logic [XW-1:0] cnt0_ext;
   logic [XW-1:0] cnt1_ext;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign acc       = req_valid && !req_stall;
   assign sel       = req_queue_select;
   assign oth       = ~req_queue_select;

   always_comb begin
      pos_ext = PW'(req_position);
      cnt_ext = PW'(cnt[sel]);
      priority if (kind_type'(req_kind) == KIND_APPEND || req_position >= POS_APPEND) begin
         ins_idx = cnt_ext;
      end else if (req_position <= POS_HEAD) begin
         ins_idx = '0;
      end else if (pos_ext - PW'(1) > cnt_ext) begin
         ins_idx = cnt_ext;
      end else begin
         ins_idx = pos_ext - PW'(1);
      end
   end

   always_comb begin
      for (int q = 0; q < 2; q++) begin
         ctrl[q]      = '0;
         idx[q]       = '0;
         new_name[q]  = req_entry_name[NW-1:0];
         new_value[q] = req_entry_value;
      end
      status_in   = ST_DONE;
      mv_name_in  = '0;
      mv_value_in = '0;

      unique case (kind_type'(req_kind))
         KIND_APPEND, KIND_INSERT: begin
            if (cnt[sel] == CW'(QUEUE_DEPTH)) begin
               status_in = ST_FULL;
            end else begin
               ctrl[sel].ins = acc;
               idx[sel]      = IW'(ins_idx);
            end
         end
         KIND_MOVE: begin
            if (cnt[sel] == '0) begin
               status_in = ST_EMPTY;
            end else if (cnt[oth] == CW'(QUEUE_DEPTH)) begin
               status_in = ST_FULL;
            end else begin
               ctrl[oth].ins = acc;
               idx[oth]      = IW'(cnt[oth]);
               new_name[oth] = head_name[sel];
               new_value[oth] = head_value[sel];
               ctrl[sel].pop = acc;
               mv_name_in    = head_name[sel];
               mv_value_in   = head_value[sel];
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   for (genvar q = 0; q < 2; q++) begin : g_row
      dqpi_row #(
         .DEPTH(QUEUE_DEPTH),
         .CW   (CW),
         .IW   (IW),
         .NW   (NW)
      ) u_row (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl[q]),
         .ins_idx    (idx[q]),
         .new_name   (new_name[q]),
         .new_value  (new_value[q]),
         .head_name  (head_name[q]),
         .head_value (head_value[q]),
         .count      (cnt[q])
      );
   end

   always_comb begin
      priority if (acc) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         status_ff   <= status_in;
         mv_name_ff  <= mv_name_in;
         mv_value_ff <= mv_value_in;
      end
   end

   assign cnt0_ext         = XW'(cnt[0]);
   assign cnt1_ext         = XW'(cnt[1]);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_count_first  = cnt0_ext[4:0];
   assign rsp_count_second = cnt1_ext[4:0];
   assign rsp_moved_name   = 64'(mv_name_ff);
   assign rsp_moved_value  = mv_value_ff;

endmodule

`default_nettype wire

// ===== rtl/dqpi_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dqpi_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_stall,
   input wire [1:0]  req_kind,
   input wire        req_queue_select,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [1:0]  rsp_status,
   input wire [4:0]  rsp_count_first,
   input wire [4:0]  rsp_count_second,
   input wire [63:0] rsp_moved_name,
   input wire [31:0] rsp_moved_value
);
   import dqpi_pkg::*;

   logic acc;
   assign acc = req_valid && !req_stall;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && rsp_count_first == 5'd0 && rsp_count_second == 5'd0)
      else $error("queues not empty after reset");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      acc |=> rsp_valid)
      else $error("accepted item gave no result");

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_moved_name) && $stable(rsp_moved_value))
      else $error("stalled result changed");

   a_no_move_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |-> rsp_moved_name == 64'd0
         && rsp_moved_value == 32'd0)
      else $error("moved entry reported on failed request");

   a_append_counts: assert property (@(posedge clock) disable iff (reset)
      acc && req_kind == KIND_APPEND && !req_queue_select
      |=> rsp_status == ST_FULL || rsp_count_first == $past(rsp_count_first) + 5'd1)
      else $error("append did not grow queue 0");

endmodule

bind dual_queue_positional_insert dqpi_checker u_dqpi_checker (.*);

`default_nettype wire
